// ===== rtl/tssm_pkg.sv =====
// tssm_pkg: shared types, codes and defaults for the task state semaphore manager
// depends on nothing; imported by task_state_semaphore_manager
package tssm_pkg;

    // default sizes
    localparam int TASKS_DEF       = 16;
    localparam int SEMAPHORES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // event kinds
    localparam logic [3:0] K_TICK    = 4'd0;
    localparam logic [3:0] K_START   = 4'd1;
    localparam logic [3:0] K_EXIT    = 4'd2;
    localparam logic [3:0] K_SLEEP   = 4'd3;
    localparam logic [3:0] K_WAKEUP  = 4'd4;
    localparam logic [3:0] K_VBL     = 4'd5;
    localparam logic [3:0] K_LOCK    = 4'd6;
    localparam logic [3:0] K_UNLOCK  = 4'd7;
    localparam logic [3:0] K_SEND    = 4'd8;
    localparam logic [3:0] K_ISEND   = 4'd9;
    localparam logic [3:0] K_RECEIVE = 4'd10;
    localparam logic [3:0] K_PICK    = 4'd11;
    localparam logic [3:0] K_QUERY   = 4'd12;

    // task states
    localparam logic [2:0] TS_DEAD  = 3'd0;
    localparam logic [2:0] TS_READY = 3'd1;
    localparam logic [2:0] TS_SLEEP = 3'd2;
    localparam logic [2:0] TS_VBL   = 3'd3;
    localparam logic [2:0] TS_PEND  = 3'd4;
    localparam logic [2:0] TS_SEND  = 3'd5;
    localparam logic [2:0] TS_RECV  = 3'd6;

    // one task table entry
    typedef struct packed {
        logic [2:0]  state;
        logic [7:0]  wake;
        logic        full;
        logic        intr;
        logic [3:0]  sender;
        logic [31:0] vbl;
    } task_word_t;

    localparam task_word_t TASK_WORD_RESET = '{
        state: TS_DEAD, wake: 8'd0, full: 1'b0, intr: 1'b0, sender: 4'd0, vbl: 32'd0
    };

endpackage

// ===== rtl/task_state_semaphore_manager.sv =====
// task_state_semaphore_manager: cooperative scheduler kernel, one event per item
// depends on tssm_pkg (types, kind and state codes, defaults)
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tuser kind, s_tdata other event fields
//  m       | out | m_tvalid/m_tready  | m_tdata result fields
//  cfg     | in  | cfg_we             | cfg_wdata boot task id
//
// tick and pick sweep the task table, reading every entry in turn
// other events make up to two read-modify-write passes on the task table
// the task table is one memory with registered read; per-entry valid bits, cleared
// by reset, make unwritten entries read as dead with empty mailbox
// a finished result waits in the output register while the next item is accepted

module task_state_semaphore_manager #(
    parameter int TASKS       = tssm_pkg::TASKS_DEF,
    parameter int SEMAPHORES  = tssm_pkg::SEMAPHORES_DEF,
    parameter int QUEUE_DEPTH = tssm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // caller_in_task, caller, target, source_any, sem_index, wait_count, zero pad
    input  logic [31:0] s_tdata,
    // kind
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok, task_id, from_interrupt, task_state, tick_count, zero pad
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata
);
    import tssm_pkg::*;

    localparam int TW  = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW  = $clog2(TASKS + 1);
    localparam int SW  = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QN  = SEMAPHORES * QUEUE_DEPTH;
    localparam int QAW = (QN > 1) ? $clog2(QN) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_SWEEP, S_QWAIT, S_RD, S_MOD, S_QRY, S_QDATA, S_FIN
    } state_t;

    state_t state_reg;

    // latched event
    logic [3:0]  kind_reg;
    logic        in_task_reg;
    logic [3:0]  caller_reg;
    logic [3:0]  target_reg;
    logic        any_reg;
    logic [2:0]  sem_reg;
    logic [15:0] count_reg;
    logic [3:0]  boot_reg;

    logic [31:0] tick_reg;
    logic [TW-1:0] addr_reg;
    logic        phase_b_reg;
    logic [CW-1:0] cnt_reg;
    logic        pv_reg;
    logic [TW-1:0] pidx_reg;
    logic        found_reg;

    logic        res_ok_reg;
    logic [3:0]  res_tid_reg;
    logic        res_intr_reg;
    logic [2:0]  res_state_reg;
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    // semaphore control
    logic [SEMAPHORES-1:0] held_reg;
    logic [3:0]     holder_reg [SEMAPHORES];
    logic [LW-1:0]  len_reg    [SEMAPHORES];
    logic [QPW-1:0] head_reg   [SEMAPHORES];

    // task table and waiter memory
    task_word_t    task_mem [TASKS];
    logic [TASKS-1:0] valid_reg;
    task_word_t    rd_data_reg;
    logic          rd_valid_reg;
    logic [3:0]    wait_mem [QN];
    logic [3:0]    wq_rdata_reg;

    // derived event fields
    logic [7:0]    caller_ext, target_ext, me_ext, sem_ext, next_ext;
    logic [3:0]    me;
    logic          caller_lt, target_ok, me_ok, sem_ok, next_ok;
    logic [TW-1:0] caller_idx, target_idx, me_idx, next_idx;
    logic [SW-1:0] sidx;

    assign me         = in_task_reg ? caller_reg : boot_reg;
    assign caller_ext = 8'(caller_reg);
    assign target_ext = 8'(target_reg);
    assign me_ext     = 8'(me);
    assign sem_ext    = 8'(sem_reg);
    assign next_ext   = 8'(wq_rdata_reg);
    assign caller_lt  = 32'(caller_reg) < TASKS;
    assign target_ok  = 32'(target_reg) < TASKS;
    assign me_ok      = 32'(me) < TASKS;
    assign sem_ok     = 32'(sem_reg) < SEMAPHORES;
    assign next_ok    = 32'(wq_rdata_reg) < TASKS;
    assign caller_idx = caller_ext[TW-1:0];
    assign target_idx = target_ext[TW-1:0];
    assign me_idx     = me_ext[TW-1:0];
    assign next_idx   = next_ext[TW-1:0];
    assign sidx       = sem_ext[SW-1:0];

    // effective read word
    task_word_t eff;
    assign eff = rd_valid_reg ? rd_data_reg : TASK_WORD_RESET;

    logic [31:0] vbl_diff;
    assign vbl_diff = tick_reg - eff.vbl;

    // waiter queue positions
    logic [LW:0]    tail_sum;
    logic [QPW-1:0] tail_pos, head_inc;
    logic [QAW-1:0] wq_waddr, wq_raddr;
    assign tail_sum = (LW + 1)'(head_reg[sidx]) + (LW + 1)'(len_reg[sidx]);
    assign tail_pos = (tail_sum >= (LW + 1)'(QUEUE_DEPTH))
        ? QPW'(tail_sum - (LW + 1)'(QUEUE_DEPTH)) : QPW'(tail_sum);
    assign head_inc = (32'(head_reg[sidx]) + 1 == QUEUE_DEPTH)
        ? '0 : head_reg[sidx] + QPW'(1);
    assign wq_waddr = QAW'(32'(sidx) * QUEUE_DEPTH + 32'(tail_pos));
    assign wq_raddr = QAW'(32'(sidx) * QUEUE_DEPTH + 32'(head_reg[sidx]));

    // read-modify-write of one task entry
    task_word_t mod_word;
    logic       mod_ok, mod_intr;
    logic [3:0] mod_tid;
    always_comb
    begin
        mod_word = eff;
        mod_ok   = 1'b0;
        mod_intr = 1'b0;
        mod_tid  = 4'd0;
        if (phase_b_reg)
        begin
            mod_word.state = TS_SEND;
        end
        else
        begin
            unique case (kind_reg)
                K_START:
                begin
                    mod_word.state = TS_READY;
                    mod_word.wake  = 8'd0;
                end
                K_EXIT:
                begin
                    mod_word.state = TS_DEAD;
                end
                K_SLEEP:
                begin
                    mod_word.state = (eff.wake != 8'd0) ? TS_READY : TS_SLEEP;
                    mod_word.wake  = 8'd0;
                end
                K_WAKEUP:
                begin
                    if (eff.state == TS_SLEEP)
                        mod_word.state = TS_READY;
                    else if (eff.state == TS_READY && eff.wake != 8'hFF)
                        mod_word.wake = eff.wake + 8'd1;
                end
                K_VBL:
                begin
                    mod_word.vbl   = tick_reg + 32'(count_reg);
                    mod_word.state = TS_VBL;
                end
                K_LOCK:
                begin
                    mod_word.state = TS_PEND;
                end
                K_UNLOCK:
                begin
                    mod_word.state = TS_READY;
                end
                K_SEND:
                begin
                    mod_word.full   = 1'b1;
                    mod_word.sender = me;
                    mod_word.intr   = 1'b0;
                    if (eff.state == TS_RECV)
                        mod_word.state = TS_READY;
                end
                K_ISEND:
                begin
                    if (eff.state == TS_RECV)
                    begin
                        mod_word.full   = 1'b1;
                        mod_word.intr   = 1'b1;
                        mod_word.sender = 4'd0;
                        mod_word.state  = TS_READY;
                        mod_ok          = 1'b1;
                    end
                end
                K_RECEIVE:
                begin
                    if (eff.full && (any_reg || (!eff.intr && eff.sender == target_reg)))
                    begin
                        mod_word.full = 1'b0;
                        mod_ok        = 1'b1;
                        mod_intr      = eff.intr;
                        mod_tid       = eff.intr ? 4'd0 : eff.sender;
                    end
                    else if (in_task_reg)
                    begin
                        mod_word.state = TS_RECV;
                    end
                end
                default:
                begin
                    mod_word = eff;
                end
            endcase
        end
    end

    // task table write and read address
    logic          mem_we;
    logic [TW-1:0] mem_wa, mem_ra;
    task_word_t    mem_wd;
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = mod_word;
        mem_ra = addr_reg;
        case (state_reg)
            S_SWEEP:
            begin
                mem_ra = cnt_reg[TW-1:0];
                mem_wa = pidx_reg;
                mem_wd = eff;
                mem_wd.state = TS_READY;
                mem_we = pv_reg && kind_reg == K_TICK && eff.state == TS_VBL && !vbl_diff[31];
            end
            S_MOD:
            begin
                mem_we = 1'b1;
            end
            S_QRY:
            begin
                mem_ra = target_idx;
            end
            default:
            begin
                mem_ra = addr_reg;
            end
        endcase
    end

    // task table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            task_mem[mem_wa] <= mem_wd;
        rd_data_reg <= task_mem[mem_ra];
    end

    // task table valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                valid_reg[mem_wa] <= 1'b1;
            rd_valid_reg <= valid_reg[mem_ra];
        end
    end

    // waiter queue memory
    logic wq_we;
    assign wq_we = state_reg == S_DISP && kind_reg == K_LOCK && sem_ok && in_task_reg
        && caller_lt && held_reg[sidx] && 32'(len_reg[sidx]) < QUEUE_DEPTH;
    always_ff @(posedge clk)
    begin
        if (wq_we)
            wait_mem[wq_waddr] <= caller_reg;
        wq_rdata_reg <= wait_mem[wq_raddr];
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            boot_reg <= 4'd0;
        else if (cfg_we)
            boot_reg <= cfg_wdata;
    end

    // sequencer, semaphore control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tick_reg     <= 32'd0;
            phase_b_reg  <= 1'b0;
            cnt_reg      <= '0;
            pv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            held_reg     <= '0;
            for (int i = 0; i < SEMAPHORES; i++)
            begin
                holder_reg[i] <= 4'd0;
                len_reg[i]    <= '0;
                head_reg[i]   <= '0;
            end
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != S_FIN)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg    <= s_tuser;
                        in_task_reg <= s_tdata[0];
                        caller_reg  <= s_tdata[4:1];
                        target_reg  <= s_tdata[8:5];
                        any_reg     <= s_tdata[9];
                        sem_reg     <= s_tdata[12:10];
                        count_reg   <= s_tdata[28:13];
                        state_reg   <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    res_tid_reg  <= 4'd0;
                    res_intr_reg <= 1'b0;
                    phase_b_reg  <= 1'b0;
                    cnt_reg      <= '0;
                    pv_reg       <= 1'b0;
                    found_reg    <= 1'b0;
                    unique case (kind_reg)
                        K_TICK:
                        begin
                            res_ok_reg <= 1'b0;
                            tick_reg   <= tick_reg + 32'd1;
                            state_reg  <= S_SWEEP;
                        end
                        K_PICK:
                        begin
                            res_ok_reg <= 1'b0;
                            state_reg  <= S_SWEEP;
                        end
                        K_START, K_WAKEUP, K_ISEND:
                        begin
                            res_ok_reg <= 1'b0;
                            addr_reg   <= target_idx;
                            state_reg  <= target_ok ? S_RD : S_QRY;
                        end
                        K_EXIT, K_SLEEP:
                        begin
                            res_ok_reg <= 1'b0;
                            addr_reg   <= caller_idx;
                            state_reg  <= (in_task_reg && caller_lt) ? S_RD : S_QRY;
                        end
                        K_VBL:
                        begin
                            res_ok_reg <= 1'b0;
                            addr_reg   <= caller_idx;
                            if (!in_task_reg)
                            begin
                                tick_reg  <= tick_reg + 32'(count_reg);
                                state_reg <= S_QRY;
                            end
                            else
                            begin
                                state_reg <= caller_lt ? S_RD : S_QRY;
                            end
                        end
                        K_LOCK:
                        begin
                            addr_reg <= caller_idx;
                            if (sem_ok && !in_task_reg)
                            begin
                                res_ok_reg <= 1'b1;
                                state_reg  <= S_QRY;
                            end
                            else if (sem_ok && caller_lt)
                            begin
                                if (!held_reg[sidx])
                                begin
                                    held_reg[sidx]   <= 1'b1;
                                    holder_reg[sidx] <= caller_reg;
                                    res_ok_reg       <= 1'b1;
                                    state_reg        <= S_QRY;
                                end
                                else
                                begin
                                    if (32'(len_reg[sidx]) < QUEUE_DEPTH)
                                        len_reg[sidx] <= len_reg[sidx] + LW'(1);
                                    res_ok_reg <= 1'b0;
                                    state_reg  <= S_RD;
                                end
                            end
                            else
                            begin
                                res_ok_reg <= 1'b0;
                                state_reg  <= S_QRY;
                            end
                        end
                        K_UNLOCK:
                        begin
                            res_ok_reg <= 1'b0;
                            if (sem_ok && len_reg[sidx] != '0)
                            begin
                                state_reg <= S_QWAIT;
                            end
                            else
                            begin
                                if (sem_ok)
                                    held_reg[sidx] <= 1'b0;
                                state_reg <= S_QRY;
                            end
                        end
                        K_SEND:
                        begin
                            res_ok_reg <= 1'b0;
                            addr_reg   <= target_idx;
                            state_reg  <= (target_ok && (!in_task_reg || caller_lt))
                                ? S_RD : S_QRY;
                        end
                        K_RECEIVE:
                        begin
                            res_ok_reg <= 1'b0;
                            addr_reg   <= me_idx;
                            state_reg  <= me_ok ? S_RD : S_QRY;
                        end
                        default:
                        begin
                            res_ok_reg <= 1'b0;
                            state_reg  <= S_QRY;
                        end
                    endcase
                end
                S_SWEEP:
                begin
                    // issue one read per cycle, check the entry read last cycle
                    if (32'(cnt_reg) < TASKS)
                    begin
                        cnt_reg  <= cnt_reg + CW'(1);
                        pidx_reg <= cnt_reg[TW-1:0];
                        pv_reg   <= 1'b1;
                    end
                    else
                    begin
                        pv_reg    <= 1'b0;
                        state_reg <= S_QRY;
                    end
                    if (pv_reg && kind_reg == K_PICK && !found_reg && eff.state == TS_READY)
                    begin
                        found_reg   <= 1'b1;
                        res_ok_reg  <= 1'b1;
                        res_tid_reg <= 4'(pidx_reg);
                    end
                end
                S_QWAIT:
                begin
                    // head waiter id now registered
                    len_reg[sidx]    <= len_reg[sidx] - LW'(1);
                    head_reg[sidx]   <= head_inc;
                    holder_reg[sidx] <= wq_rdata_reg;
                    held_reg[sidx]   <= 1'b1;
                    addr_reg         <= next_idx;
                    state_reg        <= next_ok ? S_RD : S_QRY;
                end
                S_RD:
                begin
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    if (!phase_b_reg)
                    begin
                        res_ok_reg   <= mod_ok;
                        res_tid_reg  <= mod_tid;
                        res_intr_reg <= mod_intr;
                    end
                    if (!phase_b_reg && kind_reg == K_SEND && in_task_reg)
                    begin
                        phase_b_reg <= 1'b1;
                        addr_reg    <= caller_idx;
                        state_reg   <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_QRY;
                    end
                end
                S_QRY:
                begin
                    state_reg <= S_QDATA;
                end
                S_QDATA:
                begin
                    res_state_reg <= target_ok ? eff.state : TS_DEAD;
                    state_reg     <= S_FIN;
                end
                S_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {7'd0, tick_reg, res_state_reg, res_intr_reg,
                                         res_tid_reg, res_ok_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
